/* hdl/rlm_pkg.sv */
// Shared constants and types of the RMS level meter.
`timescale 1ns / 1ps

package rlm_pkg;

    // Block limits and sample format
    localparam int MAX_BLOCK   = 4096;
    localparam int SAMPLE_BITS = 24;

    // Fixed port field widths
    localparam int SAMPLE_W = 24;
    localparam int RMS_W    = 24;
    localparam int COUNT_W  = 13;

    // Internal widths
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int MEAN_W = 2 * SAMPLE_BITS - 1;
    localparam int RAD_W  = 2 * SAMPLE_BITS;
    localparam int STEP_W = $clog2(SUM_W);

    // One closed block, handed from the accumulator to the root unit
    typedef struct packed {
        logic [SUM_W-1:0] square_sum;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } block_t;

endpackage

/* hdl/rlm_if.sv */
// Stream interfaces for the sample and result channels.
`timescale 1ns / 1ps

interface rlm_in_if;
    logic                         valid;
    logic                         ready;
    logic signed [rlm_pkg::SAMPLE_W-1:0] sample;
    logic                         last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rlm_out_if;
    logic                        valid;
    logic                        ready;
    logic [rlm_pkg::RMS_W-1:0]   rms;
    logic [rlm_pkg::COUNT_W-1:0] sample_count;
    logic                        overflow;

    modport source (output valid, output rms, output sample_count, output overflow,
                    input ready);
    modport sink   (input valid, input rms, input sample_count, input overflow,
                    output ready);
endinterface

/* hdl/rlm_front.sv */
// Sample front end: square each sample and accumulate the block.
`timescale 1ns / 1ps

module rlm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    rlm_in_if.sink               samples,
    output logic                 push_valid,
    output rlm_pkg::block_t      push_data,
    input  logic                 queue_full
);

    logic                          a_valid_reg, a_valid_next;
    logic [rlm_pkg::SQ_W-1:0]      a_sq_reg;
    logic                          a_last_reg;

    logic [rlm_pkg::SUM_W-1:0]     sum_reg, sum_next, sum_acc;
    logic [rlm_pkg::CNT_W-1:0]     count_reg, count_next, count_acc;
    logic                          ovf_reg, ovf_next, ovf_acc;

    logic [rlm_pkg::SAMPLE_BITS-1:0] raw;
    logic [rlm_pkg::SAMPLE_BITS-1:0] mag;
    logic [2*rlm_pkg::SAMPLE_BITS-1:0] sq_full;
    logic                          take;
    logic                          b_adv;
    logic                          add_ok;

    // Magnitude of the low SAMPLE_BITS bits; the most negative code maps to 2^(bits-1)
    assign raw     = samples.sample[rlm_pkg::SAMPLE_BITS-1:0];
    assign mag     = raw[rlm_pkg::SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign sq_full = mag * mag;

    // Stage B retires a beat unless it closes a block and the queue is full
    assign b_adv         = a_valid_reg && (!a_last_reg || !queue_full);
    assign samples.ready = !a_valid_reg || b_adv;
    assign take          = samples.valid && samples.ready;

    always_comb
    begin
        add_ok    = (count_reg < rlm_pkg::CNT_W'(rlm_pkg::MAX_BLOCK));
        sum_acc   = add_ok ? (sum_reg + rlm_pkg::SUM_W'(a_sq_reg)) : sum_reg;
        count_acc = add_ok ? (count_reg + 1'b1) : count_reg;
        ovf_acc   = ovf_reg || !add_ok;

        push_valid           = b_adv && a_last_reg;
        push_data.square_sum = sum_acc;
        push_data.count      = count_acc;
        push_data.overflow   = ovf_acc;

        a_valid_next = take ? 1'b1 : (b_adv ? 1'b0 : a_valid_reg);

        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (b_adv)
        begin
            if (a_last_reg)
            begin
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                sum_next   = sum_acc;
                count_next = count_acc;
                ovf_next   = ovf_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            sum_reg     <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_sq_reg   <= sq_full[rlm_pkg::SQ_W-1:0];
            a_last_reg <= samples.last;
        end
    end

endmodule

/* hdl/rlm_queue.sv */
// Two-entry queue of closed blocks between the front end and the root unit.
`timescale 1ns / 1ps

module rlm_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  rlm_pkg::block_t push_data,
    output logic            full,
    output logic            pop_valid,
    output rlm_pkg::block_t pop_data,
    input  logic            pop
);

    rlm_pkg::block_t entry_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      fill_reg, fill_next;
    logic            do_push, do_pop;

    assign full      = (fill_reg == 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/rlm_back.sv */
// Root unit: serial divide of the block sum by its count, then serial square root.
`timescale 1ns / 1ps

module rlm_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    input  rlm_pkg::block_t pop_data,
    output logic            pop,
    rlm_out_if.source       results
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    localparam int SB = rlm_pkg::SAMPLE_BITS;

    state_t                        state_reg, state_next;
    logic [rlm_pkg::STEP_W-1:0]    step_reg, step_next;

    logic [rlm_pkg::SUM_W-1:0]     dividend_reg, dividend_next;
    logic [rlm_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [rlm_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [rlm_pkg::CNT_W-1:0]     divisor_reg, divisor_next;

    logic [rlm_pkg::RAD_W-1:0]     rad_reg, rad_next;
    logic [SB:0]                   srem_reg, srem_next;
    logic [SB-1:0]                 root_reg, root_next;

    logic                          ovf_reg, ovf_next;

    logic [rlm_pkg::CNT_W:0]       div_shift;
    logic [rlm_pkg::CNT_W:0]       div_diff;
    logic                          div_ge;
    logic [SB+2:0]                 sq_shift;
    logic [SB+2:0]                 sq_trial;
    logic [SB+2:0]                 sq_diff;
    logic                          sq_ge;

    // One quotient bit per cycle; remainder stays below the divisor
    assign div_shift = {rem_reg, dividend_reg[rlm_pkg::SUM_W-1]};
    assign div_diff  = div_shift - {1'b0, divisor_reg};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});

    // One root bit per cycle, two radicand bits consumed per step
    assign sq_shift = {srem_reg, rad_reg[rlm_pkg::RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_diff  = sq_shift - sq_trial;
    assign sq_ge    = (sq_shift >= sq_trial);

    assign pop                  = (state_reg == ST_IDLE) && pop_valid;
    assign results.valid        = (state_reg == ST_OUT);
    assign results.rms          = rlm_pkg::RMS_W'(root_reg);
    assign results.sample_count = rlm_pkg::COUNT_W'(divisor_reg);
    assign results.overflow     = ovf_reg;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        dividend_next = dividend_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        rad_next      = rad_reg;
        srem_next     = srem_reg;
        root_next     = root_reg;
        ovf_next      = ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    dividend_next = pop_data.square_sum;
                    divisor_next  = pop_data.count;
                    ovf_next      = pop_data.overflow;
                    rem_next      = '0;
                    quo_next      = '0;
                    step_next     = rlm_pkg::STEP_W'(rlm_pkg::SUM_W - 1);
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next      = div_ge ? div_diff[rlm_pkg::CNT_W-1:0]
                                       : div_shift[rlm_pkg::CNT_W-1:0];
                quo_next      = {quo_reg[rlm_pkg::SUM_W-2:0], div_ge};
                dividend_next = {dividend_reg[rlm_pkg::SUM_W-2:0], 1'b0};
                step_next     = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    // An empty block reports zero
                    rad_next   = (divisor_reg == '0) ? '0
                               : {1'b0, quo_next[rlm_pkg::MEAN_W-1:0]};
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = rlm_pkg::STEP_W'(SB - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                srem_next = sq_ge ? sq_diff[SB:0] : sq_shift[SB:0];
                root_next = {root_reg[SB-2:0], sq_ge};
                rad_next  = {rad_reg[rlm_pkg::RAD_W-3:0], 2'b00};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (results.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        rad_reg      <= rad_next;
        srem_reg     <= srem_next;
        root_reg     <= root_next;
        ovf_reg      <= ovf_next;
    end

endmodule

/* hdl/rms_level_meter_core.sv */
// Top level of the block RMS level meter.
`timescale 1ns / 1ps

// Block RMS meter. Each sample beat is squared and added to the running sum
// of the current block; a beat with last set closes the block and yields one
// result beat carrying floor(sqrt(floor(sum / count))), the sample count and
// an overflow flag. Samples beyond MAX_BLOCK in one block are not summed or
// counted; they set the overflow flag instead. The front end takes one sample
// per cycle while intake does not stall. A closed block then passes through a
// two-entry queue to the root unit, which loads it, runs a one-bit-per-cycle
// divide over SUM_W quotient bits and a one-bit-per-cycle square root giving
// SAMPLE_BITS root bits, and then presents the result. Sample intake stalls
// only when a block closes while two earlier blocks still wait in the queue.

module rms_level_meter_core
(
    input  logic      clk,
    input  logic      rst_n,
    rlm_in_if.sink    samples,
    rlm_out_if.source results
);

    logic            push_valid;
    rlm_pkg::block_t push_data;
    logic            queue_full;
    logic            pop_valid;
    rlm_pkg::block_t pop_data;
    logic            pop;

    // Square and accumulate; hand each closed block to the queue
    rlm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .push_valid (push_valid),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // Decouple intake from the long-running root unit
    rlm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop)
    );

    // Divide, take the root, and hold the result beat until it is taken
    rlm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .results   (results)
    );

endmodule

/* tb/rms_block_checker.sv */
// Checker for the RMS level meter: predicts block levels and compares result beats.
`timescale 1ns / 1ps

module rms_block_checker
(
    input  logic clk,
    input  logic rst_n,
    rlm_in_if    samples,
    rlm_out_if   results,
    output int   mismatch_count,
    output int   blocks_pending
);

    typedef struct packed {
        logic [rlm_pkg::RMS_W-1:0]   rms;
        logic [rlm_pkg::COUNT_W-1:0] sample_count;
        logic                        overflow;
    } block_level_t;

    block_level_t expected_levels[$];

    // Running state of the open block
    logic [63:0] energy_sum = '0;
    int          blk_samples = 0;
    bit          blk_overflow = 1'b0;
    int          fail_total = 0;

    initial
    begin
        mismatch_count = 0;
        blocks_pending = 0;
    end

    // Sign-extend the low SAMPLE_BITS bits and take the absolute value.
    function automatic logic [63:0] magnitude_of(logic [rlm_pkg::SAMPLE_W-1:0] raw);
        logic [rlm_pkg::SAMPLE_BITS-1:0] low;
        logic [63:0]                     ext;
        low = raw[rlm_pkg::SAMPLE_BITS-1:0];
        ext = {{(64 - rlm_pkg::SAMPLE_BITS){low[rlm_pkg::SAMPLE_BITS-1]}}, low};
        return low[rlm_pkg::SAMPLE_BITS-1] ? (~ext + 64'd1) : ext;
    endfunction

    // Floor square root, one result bit per step from the top.
    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic block_level_t level_of_block(logic [63:0] sum, int n, bit ovf);
        block_level_t lvl;
        logic [63:0]  mean;
        mean             = (n != 0) ? sum / 64'(n) : 64'd0;
        lvl.rms          = rlm_pkg::RMS_W'(floor_sqrt(mean));
        lvl.sample_count = rlm_pkg::COUNT_W'(n);
        lvl.overflow     = ovf;
        return lvl;
    endfunction

    always @(posedge clk)
    begin
        block_level_t want;
        logic [63:0]  mag;
        if (!rst_n)
        begin
            energy_sum   = '0;
            blk_samples  = 0;
            blk_overflow = 1'b0;
            expected_levels.delete();
        end
        else
        begin
            // Check the result beat against the oldest pending expectation.
            if (results.valid && results.ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $display("%0t: unexpected result beat rms=%0d count=%0d overflow=%0b",
                             $time, results.rms, results.sample_count, results.overflow);
                    fail_total++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (results.rms !== want.rms)
                    begin
                        $display("%0t: rms expected %0d actual %0d",
                                 $time, want.rms, results.rms);
                        fail_total++;
                    end
                    if (results.sample_count !== want.sample_count)
                    begin
                        $display("%0t: sample_count expected %0d actual %0d",
                                 $time, want.sample_count, results.sample_count);
                        fail_total++;
                    end
                    if (results.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, want.overflow, results.overflow);
                        fail_total++;
                    end
                end
            end

            // Accumulate the sample beat; close the block on last.
            if (samples.valid && samples.ready)
            begin
                mag = magnitude_of(samples.sample);
                if (blk_samples < rlm_pkg::MAX_BLOCK)
                begin
                    energy_sum  += mag * mag;
                    blk_samples += 1;
                end
                else
                    blk_overflow = 1'b1;
                if (samples.last)
                begin
                    expected_levels.push_back(
                        level_of_block(energy_sum, blk_samples, blk_overflow));
                    energy_sum   = '0;
                    blk_samples  = 0;
                    blk_overflow = 1'b0;
                end
            end
        end
        mismatch_count <= fail_total;
        blocks_pending <= expected_levels.size();
    end

endmodule

/* tb/rms_level_meter_core_tb.sv */
// Testbench top for the RMS level meter: stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module rms_level_meter_core_tb;

    // Generous bound: about 800 beats, each possibly closing a block for the
    // root unit, plus stalls and the long hold-off, all fit well inside this.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD    = 500;
    localparam int PHASE_ITEMS  = 245;
    localparam int FULL_POS     = 2 ** (rlm_pkg::SAMPLE_W - 1) - 1;
    localparam int FULL_NEG     = -(2 ** (rlm_pkg::SAMPLE_W - 1));

    // How the samples of a block are filled
    typedef enum {FILL_RANDOM, FILL_NEG_FULL, FILL_POS_FULL} fill_t;

    logic clk;
    logic rst_n;

    rlm_in_if  samples();
    rlm_out_if results();

    int mismatch_count;
    int blocks_pending;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit hold_toggle   = 1'b0;
    int cycle_count   = 0;

    rms_level_meter_core u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results)
    );

    rms_block_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples),
        .results        (results),
        .mismatch_count (mismatch_count),
        .blocks_pending (blocks_pending)
    );

    // 12 ns clock, first rising edge at 6 ns
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rms_level_meter_core_tb: FAIL");
            $finish;
        end
    end

    // Result side: random ready, or a long hold-off when the stimulus flips
    // hold_toggle. The hold is counted here, so the sender keeps offering beats
    // meanwhile and the block's queue fills up and stalls sample intake.
    initial
    begin : result_sink
        int hold_left;
        bit seen_toggle;
        hold_left     = 0;
        seen_toggle   = 1'b0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != seen_toggle)
            begin
                seen_toggle = hold_toggle;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Mix of extremes, full-range values and values of random small size.
    function automatic logic [rlm_pkg::SAMPLE_W-1:0] random_sample();
        int pick;
        int span;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            case ($urandom_range(4))
                0:       return rlm_pkg::SAMPLE_W'(FULL_POS);
                1:       return rlm_pkg::SAMPLE_W'(FULL_NEG);
                2:       return rlm_pkg::SAMPLE_W'(0);
                3:       return rlm_pkg::SAMPLE_W'(-1);
                default: return rlm_pkg::SAMPLE_W'(1);
            endcase
        end
        if (pick < 55)
            return rlm_pkg::SAMPLE_W'($urandom);
        span = $urandom_range(rlm_pkg::SAMPLE_W - 1, 1);
        return rlm_pkg::SAMPLE_W'(int'($urandom_range((1 << span) - 1)) - (1 << (span - 1)));
    endfunction

    // Offer one sample beat and hold it until accepted. Idle cycles drop valid
    // and put noise on the payload, which the block must ignore.
    task automatic send_sample(input logic [rlm_pkg::SAMPLE_W-1:0] value,
                               input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            samples.valid  <= 1'b0;
            samples.sample <= rlm_pkg::SAMPLE_W'($urandom);
            samples.last   <= 1'($urandom_range(1));
            @(posedge clk);
        end
        samples.valid  <= 1'b1;
        samples.sample <= value;
        samples.last   <= is_last;
        do
            @(posedge clk);
        while (samples.ready !== 1'b1);
    endtask

    task automatic send_block(input int len, input fill_t fill);
        logic [rlm_pkg::SAMPLE_W-1:0] value;
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_NEG_FULL: value = rlm_pkg::SAMPLE_W'(FULL_NEG);
                FILL_POS_FULL: value = rlm_pkg::SAMPLE_W'(FULL_POS);
                default:       value = random_sample();
            endcase
            send_sample(value, i == len - 1);
        end
    endtask

    // Mostly short blocks so results come often; a few long ones.
    task automatic run_random_blocks(input int item_goal);
        int sent;
        int len;
        int roll;
        sent = 0;
        while (sent < item_goal)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                len = $urandom_range(6, 1);
            else if (roll < 95)
                len = $urandom_range(40, 7);
            else
                len = $urandom_range(150, 41);
            send_block(len, FILL_RANDOM);
            sent += len;
        end
    endtask

    // Drop valid and wait for every expected result beat to arrive.
    task automatic wait_until_drained();
        samples.valid <= 1'b0;
        do
            @(posedge clk);
        while (blocks_pending != 0);
    endtask

    initial
    begin : stimulus
        // Directed beats: full-scale positive and negative, zero, minus one,
        // floors in the divide and the root, alternating extremes, bit patterns.
        int dir_vals [22] = '{FULL_POS, FULL_NEG, 0, -1,
                              3, -4, 0,
                              FULL_POS, FULL_NEG, FULL_POS, FULL_NEG,
                              1, 0, 0, 0, 0, 0, 0,
                              'h555555, 'hAAAAAA,
                              2, 2};
        bit dir_last [22] = '{1, 1, 1, 1,
                              0, 0, 1,
                              0, 0, 0, 1,
                              0, 0, 0, 0, 0, 0, 1,
                              0, 1,
                              0, 1};

        rst_n          = 1'b0;
        samples.valid  = 1'b0;
        samples.sample = '0;
        samples.last   = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles more rarely than the receiver.
        src_idle_pct  = 37;
        sink_idle_pct <= 49;

        for (int i = 0; i < 22; i++)
            send_sample(rlm_pkg::SAMPLE_W'(dir_vals[i]), dir_last[i]);

        run_random_blocks(PHASE_ITEMS);

        // Swap the idle rates.
        src_idle_pct  = 49;
        sink_idle_pct <= 37;
        run_random_blocks(PHASE_ITEMS);

        // Pause the sender until every result is back.
        wait_until_drained();

        // Full rate on both sides.
        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        run_random_blocks(PHASE_ITEMS);

        // Long receiver hold-off while single-beat blocks keep coming.
        hold_toggle <= ~hold_toggle;
        for (int i = 0; i < 24; i++)
            send_block(1, FILL_RANDOM);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && blocks_pending == 0)
            $display("rms_level_meter_core_tb: PASS");
        else
            $display("rms_level_meter_core_tb: FAIL");
        $finish;
    end

endmodule
